// ===== sv/scc_pkg.sv =====
// Shared types, constants and helper functions of the strided convolution block.
`default_nettype none
package scc_pkg;

  localparam int KERNEL_SIZE  = 9;
  localparam int MAX_WIDTH    = 64;
  localparam int HEIGHT_LIMIT = 64;
  localparam int TAPS         = KERNEL_SIZE * KERNEL_SIZE;

  localparam int PIX_W  = 16;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W  = 7;
  localparam int STR_W  = 3;
  localparam int TAP_W  = 7;
  localparam int SLOT_W = $clog2(KERNEL_SIZE);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int FRAC_BITS   = 14;
  localparam logic [PIX_W-1:0] VALUE_MAX = 16'hFF00;

  localparam int TREE_LEVELS = $clog2(TAPS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int PROD_W      = 2 * PIX_W + 1;
  localparam int SUM_W       = PROD_W + TREE_LEVELS;
  localparam int PIPE_LEN    = TREE_LEVELS + 3;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 16;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // reciprocal of three for the stride quotient, exact for six-bit values
  localparam int DIV3_RECIP = 43;
  localparam int DIV3_SHIFT = 7;
  // reciprocal of the kernel size for the line slot of a row
  localparam int SLOT_SHIFT = 9;
  localparam int SLOT_RECIP = ((1 << SLOT_SHIFT) + KERNEL_SIZE - 1) / KERNEL_SIZE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRIDE       = 2'd2
  } scc_reg_e;

  typedef enum logic {
    MODE_COEF  = 1'b0,
    MODE_PIXEL = 1'b1
  } scc_mode_e;

  typedef struct packed {
    logic              is_pix;
    logic [PIX_W-1:0]  data;
    logic [TAP_W-1:0]  tap;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic              emit;
    logic [5:0]        out_row;
    logic [5:0]        out_col;
    logic              last;
  } scc_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [5:0]       out_row;
    logic [5:0]       out_col;
    logic             last;
  } scc_res_t;

  function automatic logic [5:0] div_stride(input logic [5:0] v, input logic [STR_W-1:0] s);
    logic [11:0] prod;
    logic [5:0]  q;
    prod = 12'(v) * 12'(DIV3_RECIP);
    case (s)
      3'd1:    q = v;
      3'd2:    q = v >> 1;
      3'd3:    q = 6'(prod >> DIV3_SHIFT);
      default: q = v >> 2;
    endcase
    return q;
  endfunction

  function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] r);
    logic [15:0] prod;
    logic [15:0] q;
    logic [15:0] rem;
    prod = 16'(r) * 16'(SLOT_RECIP);
    q    = prod >> SLOT_SHIFT;
    rem  = 16'(r) - q * 16'(KERNEL_SIZE);
    return rem[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/scc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/scc_front.sv =====
// Front end: configuration registers, raster position tracking and item classification.
`default_nettype none
module scc_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [scc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [scc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              in_mode_i,
  input  wire  [scc_pkg::PIX_W-1:0]        in_pixel_i,
  input  wire  [scc_pkg::PIX_W-1:0]        in_coef_i,
  input  wire  [scc_pkg::TAP_W-1:0]        in_tap_i,
  input  wire                              full_i,
  output logic                             push_o,
  output scc_pkg::scc_cmd_t                cmd_o
);
  import scc_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [STR_W-1:0] stride_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [DIM_W-1:0] cw, ch;
  logic [STR_W-1:0] cs;
  logic             accept, is_pix, wrap;
  logic [DIM_W-1:0] row_b, col_n, row_n;
  logic [ROW_W-1:0] row_a;
  logic [COL_W-1:0] col_a;
  logic [5:0]       r0, c0, qr, qc, qr_end, qc_end;
  logic             at_pos, aligned, big_enough;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(28);
      height_q <= DIM_W'(28);
      stride_q <= STR_W'(1);
    end else if (cfg_we_i) begin
      case (scc_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        REG_STRIDE:       stride_q <= cfg_data_i[STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    cw = (width_q == '0) ? DIM_W'(1) :
         (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
    ch = (height_q == '0) ? DIM_W'(1) :
         (height_q > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : height_q;
    cs = (stride_q == '0) ? STR_W'(1) : (stride_q > STR_W'(4)) ? STR_W'(4) : stride_q;

    in_ready_o = !full_i;
    accept     = in_valid_i && !full_i;
    is_pix     = (scc_mode_e'(in_mode_i) == MODE_PIXEL);

    // a register change may leave the position past the image: start a new row
    wrap  = ({1'b0, col_q} >= cw);
    col_a = wrap ? '0 : col_q;
    row_b = {1'b0, row_q} + DIM_W'(wrap);
    row_a = (row_b >= ch) ? '0 : row_b[ROW_W-1:0];

    at_pos = (row_a >= ROW_W'(KERNEL_SIZE - 1)) && (col_a >= COL_W'(KERNEL_SIZE - 1));
    r0     = 6'(row_a - ROW_W'(KERNEL_SIZE - 1));
    c0     = 6'(col_a - COL_W'(KERNEL_SIZE - 1));
    qr     = div_stride(r0, cs);
    qc     = div_stride(c0, cs);
    aligned = ((9'(qr) * 9'(cs)) == 9'(r0)) && ((9'(qc) * 9'(cs)) == 9'(c0));
    big_enough = (ch >= DIM_W'(KERNEL_SIZE)) && (cw >= DIM_W'(KERNEL_SIZE));
    qr_end = div_stride(6'(ch - DIM_W'(KERNEL_SIZE)), cs);
    qc_end = div_stride(6'(cw - DIM_W'(KERNEL_SIZE)), cs);

    col_n = DIM_W'(col_a) + DIM_W'(1);
    row_n = DIM_W'(row_a) + DIM_W'(1);
    col_d = col_q;
    row_d = row_q;
    if (accept && is_pix) begin
      if (col_n >= cw) begin
        col_d = '0;
        row_d = (row_n >= ch) ? '0 : row_n[ROW_W-1:0];
      end else begin
        col_d = col_n[COL_W-1:0];
        row_d = row_a;
      end
    end

    cmd_o.is_pix  = is_pix;
    cmd_o.data    = is_pix ? in_pixel_i : in_coef_i;
    cmd_o.tap     = in_tap_i;
    cmd_o.slot    = row_slot(row_a);
    cmd_o.col     = col_a;
    cmd_o.emit    = at_pos && aligned;
    cmd_o.out_row = qr;
    cmd_o.out_col = qc;
    cmd_o.last    = big_enough && (qr == qr_end) && (qc == qc_end);

    // drop coefficient items whose index lies outside the kernel
    push_o = accept && (is_pix || (in_tap_i < TAP_W'(TAPS)));
  end
endmodule
`default_nettype wire

// ===== sv/scc_cmdq.sv =====
// Short command queue between the front end and the compute back end.
`default_nettype none
module scc_cmdq (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  scc_pkg::scc_cmd_t      cmd_i,
  output logic                   full_o,
  output logic                   valid_o,
  output scc_pkg::scc_cmd_t      cmd_o,
  input  wire                    pop_i
);
  import scc_pkg::*;

  scc_cmd_t             mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_q, rd_q;
  logic [CMDQ_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (CMDQ_AW+1)'(push_i) - (CMDQ_AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== sv/scc_back.sv =====
// Back end: line store, sliding window, parallel multipliers, adder tree and clamp.
`default_nettype none
module scc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pop_i,
  input  scc_pkg::scc_cmd_t    cmd_i,
  output logic                 res_valid_o,
  output scc_pkg::scc_res_t    res_o
);
  import scc_pkg::*;

  logic [PIX_W-1:0]        rd_data [KERNEL_SIZE];
  logic [PIX_W-1:0]        colv    [KERNEL_SIZE];
  logic [PIX_W-1:0]        win_q   [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0]        weight_q [TAPS];
  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [SUM_W-1:0]  node_q [1:TREE_LEAVES-1];
  scc_cmd_t                ctl_q   [PIPE_LEN];
  logic [PIPE_LEN-1:0]     vld_q;

  logic signed [SUM_W-1:0]     acc;
  logic [SUM_W-FRAC_BITS-1:0]  shifted;
  logic [PIX_W-1:0]            value;
  scc_cmd_t                    tail;

  for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_line
    scc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk_i   (clk_i),
      .we_i    (pop_i && cmd_i.is_pix && (cmd_i.slot == SLOT_W'(i))),
      .waddr_i (cmd_i.col),
      .wdata_i (cmd_i.data),
      .raddr_i (cmd_i.col),
      .rdata_o (rd_data[i])
    );
  end

  // pick the older rows of the new window column; the bottom row is the new pixel
  always_comb begin
    logic [SLOT_W:0] sel;
    for (int kr = 0; kr < KERNEL_SIZE - 1; kr++) begin
      sel = (SLOT_W+1)'(ctl_q[0].slot) + (SLOT_W+1)'(kr + 1);
      if (sel >= (SLOT_W+1)'(KERNEL_SIZE)) sel = sel - (SLOT_W+1)'(KERNEL_SIZE);
      colv[kr] = rd_data[sel[SLOT_W-1:0]];
    end
    colv[KERNEL_SIZE-1] = ctl_q[0].data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LEN-2:0], pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= cmd_i;
    for (int p = 1; p < PIPE_LEN; p++) begin
      ctl_q[p] <= ctl_q[p-1];
    end
    if (vld_q[0] && ctl_q[0].is_pix) begin
      for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
        for (int kc = 0; kc < KERNEL_SIZE - 1; kc++) begin
          win_q[kr][kc] <= win_q[kr][kc+1];
        end
        win_q[kr][KERNEL_SIZE-1] <= colv[kr];
      end
    end
    // weights change in step with the multipliers so earlier pixels keep old weights
    if (vld_q[1] && !ctl_q[1].is_pix) begin
      weight_q[ctl_q[1].tap] <= ctl_q[1].data;
    end
    for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
      for (int kc = 0; kc < KERNEL_SIZE; kc++) begin
        prod_q[kr*KERNEL_SIZE+kc] <= $signed(weight_q[kr*KERNEL_SIZE+kc])
                                     * $signed({1'b0, win_q[kr][kc]});
      end
    end
  end

  for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
    logic signed [SUM_W-1:0] lft, rgt;
    if (2 * n >= TREE_LEAVES) begin : g_leaf
      if (2 * n - TREE_LEAVES < TAPS) begin : g_l
        assign lft = SUM_W'(prod_q[2*n-TREE_LEAVES]);
      end else begin : g_lz
        assign lft = '0;
      end
      if (2 * n + 1 - TREE_LEAVES < TAPS) begin : g_r
        assign rgt = SUM_W'(prod_q[2*n+1-TREE_LEAVES]);
      end else begin : g_rz
        assign rgt = '0;
      end
    end else begin : g_inner
      assign lft = node_q[2*n];
      assign rgt = node_q[2*n+1];
    end
    always_ff @(posedge clk_i) begin
      node_q[n] <= lft + rgt;
    end
  end

  always_comb begin
    acc     = node_q[1];
    shifted = acc[SUM_W-1:FRAC_BITS];
    if (acc[SUM_W-1] || (acc == '0)) begin
      value = '0;
    end else if (shifted > (SUM_W-FRAC_BITS)'(VALUE_MAX)) begin
      value = VALUE_MAX;
    end else begin
      value = shifted[PIX_W-1:0];
    end
    tail = ctl_q[PIPE_LEN-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= vld_q[PIPE_LEN-1] && tail.is_pix && tail.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.value   <= value;
    res_o.out_row <= tail.out_row;
    res_o.out_col <= tail.out_col;
    res_o.last    <= tail.last;
  end
endmodule
`default_nettype wire

// ===== sv/scc_outq.sv =====
// Result queue that holds finished items until the sink takes them.
`default_nettype none
module scc_outq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            push_i,
  input  scc_pkg::scc_res_t              res_i,
  output logic [scc_pkg::OUTQ_AW:0]      count_o,
  output logic                           valid_o,
  output scc_pkg::scc_res_t              res_o,
  input  wire                            pop_i
);
  import scc_pkg::*;

  scc_res_t            mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  wr_q, rd_q;
  logic [OUTQ_AW:0]    cnt_q;

  assign count_o = cnt_q;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (OUTQ_AW+1)'(push_i) - (OUTQ_AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== sv/strided_conv2d_clamp.sv =====
// Top level of the strided 9x9 convolution with clamp to 0..255.0.
// Coefficient items (tuser 0) load kernel taps, pixel items (tuser 1) arrive in raster
// order; a result with its output row and column leaves when a stride-aligned window
// completes, tlast marking the last one of the image. The block takes one item per
// clock cycle, sustained as long as the sink keeps taking results: nine line RAMs of
// 64 entries each read one column per cycle, 81 multipliers work in parallel and a
// seven-level registered adder tree sums them. A result is presented once its pixel has
// passed the command queue and the pipeline registers; a 16-entry result queue, with credit
// counted against results in flight, lets input flow on in an output stall until credit runs out.
`default_nettype none
module strided_conv2d_clamp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [scc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [scc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] pixel, [31:16] coefficient, [38:32] coefficient_index, [39] zero
  input  wire  [39:0]                    s_axis_tdata,
  // [0] mode
  input  wire  [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [15:0] value, [21:16] out_row, [27:22] out_col, [31:28] zero
  output logic [31:0]                    m_axis_tdata,
  output logic                           m_axis_tlast
);
  import scc_pkg::*;

  scc_cmd_t          fe_cmd, q_cmd;
  scc_res_t          be_res, oq_res;
  logic              fe_push, q_full, q_valid, q_pop, be_valid;
  logic [OUTQ_AW:0]  oq_cnt;
  logic [OUTQ_AW:0]  inflight_q, inflight_d;
  logic [OUTQ_AW+1:0] budget;

  scc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser[0]),
    .in_pixel_i (s_axis_tdata[15:0]),
    .in_coef_i  (s_axis_tdata[31:16]),
    .in_tap_i   (s_axis_tdata[38:32]),
    .full_i     (q_full),
    .push_o     (fe_push),
    .cmd_o      (fe_cmd)
  );

  scc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // hand an item to the pipeline only when the result queue has room for it
  assign budget = (OUTQ_AW+2)'(oq_cnt) + (OUTQ_AW+2)'(inflight_q);
  assign q_pop  = q_valid && (budget < (OUTQ_AW+2)'(OUTQ_DEPTH));

  always_comb begin
    inflight_d = inflight_q;
    if (q_pop && q_cmd.is_pix && q_cmd.emit) inflight_d = inflight_d + 1'b1;
    if (be_valid) inflight_d = inflight_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  scc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (q_pop),
    .cmd_i       (q_cmd),
    .res_valid_o (be_valid),
    .res_o       (be_res)
  );

  scc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (be_valid),
    .res_i   (be_res),
    .count_o (oq_cnt),
    .valid_o (m_axis_tvalid),
    .res_o   (oq_res),
    .pop_i   (m_axis_tvalid && m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, oq_res.out_col, oq_res.out_row, oq_res.value};
  assign m_axis_tlast = oq_res.last;

  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    budget <= (OUTQ_AW+2)'(OUTQ_DEPTH))
    else $error("result credit exceeds queue depth");

  a_result_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    be_valid |-> (inflight_q != '0))
    else $error("result produced with no item in flight");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    be_valid |-> (oq_cnt < (OUTQ_AW+1)'(OUTQ_DEPTH)))
    else $error("result queue full when a result arrives");
endmodule
`default_nettype wire
